// ===== sv/bank_switch_mapper_scanline_irq_macros.svh =====
// Assertion macros shared by the mapper checker.
`ifndef BANK_SWITCH_MAPPER_SCANLINE_IRQ_MACROS_SVH
`define BANK_SWITCH_MAPPER_SCANLINE_IRQ_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BSM_ASSERT_NOW(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error("bsm assertion failed");

// Next-cycle implication, disabled while reset is high.
`define BSM_ASSERT_NEXT(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error("bsm assertion failed");

`endif

// ===== sv/bsm_pkg.sv =====
// Shared types and constants of the bank-switching mapper.
`timescale 1ns / 1ps

package bsm_pkg;

   localparam int ACTION_WIDTH   = 2;
   localparam int ADDRESS_WIDTH  = 16;
   localparam int VALUE_WIDTH    = 8;
   localparam int BANK_WIDTH     = 8;
   localparam int COUNT_WIDTH    = 9;
   localparam int CSR_IDX_WIDTH  = 2;
   localparam int NUM_BANK_REGS  = 8;
   localparam int REG_SEL_WIDTH  = 3;

   localparam logic [COUNT_WIDTH-1:0] PRG_COUNT_RESET = 9'd32;
   localparam logic [COUNT_WIDTH-1:0] CHR_COUNT_RESET = 9'd256;

   typedef enum logic [ACTION_WIDTH-1:0] {
      ACT_WRITE = 2'd0,
      ACT_TICK  = 2'd1,
      ACT_PRG   = 2'd2,
      ACT_CHR   = 2'd3
   } action_type;

   // CPU register code: address bits 14:13 and bit 0 (mask E001h, bit 15 set)
   typedef enum logic [2:0] {
      REG_BANK_SELECT = 3'b000,
      REG_BANK_DATA   = 3'b001,
      REG_MIRROR      = 3'b010,
      REG_WRAM        = 3'b011,
      REG_IRQ_LATCH   = 3'b100,
      REG_IRQ_RELOAD  = 3'b101,
      REG_IRQ_DISABLE = 3'b110,
      REG_IRQ_ENABLE  = 3'b111
   } reg_code_type;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_PRG_COUNT = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_CHR_COUNT = 2'd1;

endpackage

// ===== sv/bank_switch_mapper_scanline_irq.sv =====
// Bank-switching mapper with scanline IRQ counter: top level.
// Each request (register write, scanline tick, program or pattern lookup) is
// decoded and applied in the cycle it is accepted, and its response appears
// in the response register on the next cycle. A new request can be taken
// every cycle while the consumer takes responses, since the response
// register drains while the next request is decoded. The only stall is a
// full response register that the consumer has not taken. Bank counts on
// the csr port are assumed to be written only while no request is in flight.
`timescale 1ns / 1ps

module bank_switch_mapper_scanline_irq (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [bsm_pkg::ACTION_WIDTH-1:0]    req_action,
   input  logic [bsm_pkg::ADDRESS_WIDTH-1:0]   req_address,
   input  logic [bsm_pkg::VALUE_WIDTH-1:0]     req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [bsm_pkg::BANK_WIDTH-1:0]      rsp_bank,
   output logic                                rsp_irq_pending,
   output logic                                rsp_mirror_horizontal,
   output logic                                rsp_wram_writable,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bsm_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  logic [bsm_pkg::COUNT_WIDTH-1:0]     csr_data
);
   import bsm_pkg::*;

   logic [COUNT_WIDTH-1:0] prg_count_ff, prg_count_in;
   logic [COUNT_WIDTH-1:0] chr_count_ff, chr_count_in;

   logic [BANK_WIDTH-1:0]    bank_regs_ff [NUM_BANK_REGS];
   logic [BANK_WIDTH-1:0]    bank_regs_in [NUM_BANK_REGS];
   logic                     prg_mode_ff, prg_mode_in;
   logic                     chr_mode_ff, chr_mode_in;
   logic [REG_SEL_WIDTH-1:0] reg_select_ff, reg_select_in;
   logic [BANK_WIDTH-1:0]    irq_count_ff, irq_count_in;
   logic [BANK_WIDTH-1:0]    irq_latch_ff, irq_latch_in;
   logic                     reload_flag_ff, reload_flag_in;
   logic                     irq_on_ff, irq_on_in;
   logic                     irq_flag_ff, irq_flag_in;
   logic                     mirror_bit_ff, mirror_bit_in;
   logic                     wram_bit_ff, wram_bit_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [BANK_WIDTH-1:0]    rsp_bank_ff, rsp_bank_in;
   logic                     rsp_irq_ff;
   logic                     rsp_mirror_ff;
   logic                     rsp_wram_ff;

   logic                     accept;
   action_type               act;
   reg_code_type             reg_code;
   logic [COUNT_WIDTH-1:0]   prg_last, prg_second;
   logic [BANK_WIDTH-1:0]    prg_mask, chr_mask;
   logic [BANK_WIDTH-1:0]    prg_raw, chr_raw, prg_bank, chr_bank;
   logic [REG_SEL_WIDTH-1:0] chr_slot, chr_idx;
   logic [COUNT_WIDTH-1:0]   chr_last;

   assign req_ready = ~reset & (~rsp_valid_ff | rsp_ready);
   assign csr_ready = ~reset;
   assign accept    = req_valid & req_ready;
   assign act       = action_type'(req_action);
   assign reg_code  = reg_code_type'({req_address[14:13], req_address[0]});

   // program lookup: fixed banks are count-2 and count-1, all masked
   assign prg_last   = prg_count_ff - 9'd1;
   assign prg_second = prg_count_ff - 9'd2;
   assign prg_mask   = prg_last[BANK_WIDTH-1:0];

   always_comb begin
      unique case (req_address[14:13])
         2'd3:    prg_raw = prg_last[BANK_WIDTH-1:0];
         2'd1:    prg_raw = bank_regs_ff[7];
         default: begin
            // R6 sits in slot 0 for mode 0, slot 2 for mode 1
            if ((req_address[14:13] == 2'd0) == ~prg_mode_ff) begin
               prg_raw = bank_regs_ff[6];
            end else begin
               prg_raw = prg_second[BANK_WIDTH-1:0];
            end
         end
      endcase
      prg_bank = req_address[15] ? (prg_raw & prg_mask) : '0;
   end

   // pattern lookup: 2K pairs from R0/R1, 1K slots from R2-R5
   assign chr_last = chr_count_ff - 9'd1;
   assign chr_mask = chr_last[BANK_WIDTH-1:0];
   assign chr_slot = req_address[12:10] ^ {chr_mode_ff, 2'b00};

   always_comb begin
      if (chr_slot[2]) begin
         chr_idx = chr_slot - 3'd2;
      end else begin
         chr_idx = {1'b0, chr_slot[2:1]};
      end
      chr_raw = bank_regs_ff[chr_idx];
      if (!chr_slot[2]) begin
         chr_raw[0] = chr_slot[0];
      end
      chr_bank = (req_address[15:13] == 3'b000) ? (chr_raw & chr_mask) : '0;
   end

   always_comb begin
      prg_count_in = prg_count_ff;
      chr_count_in = chr_count_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_PRG_COUNT) begin
            prg_count_in = csr_data;
         end else if (csr_index == CSR_CHR_COUNT) begin
            chr_count_in = csr_data;
         end
      end
   end

   always_comb begin
      bank_regs_in   = bank_regs_ff;
      prg_mode_in    = prg_mode_ff;
      chr_mode_in    = chr_mode_ff;
      reg_select_in  = reg_select_ff;
      irq_count_in   = irq_count_ff;
      irq_latch_in   = irq_latch_ff;
      reload_flag_in = reload_flag_ff;
      irq_on_in      = irq_on_ff;
      irq_flag_in    = irq_flag_ff;
      mirror_bit_in  = mirror_bit_ff;
      wram_bit_in    = wram_bit_ff;
      rsp_bank_in    = '0;
      if (accept) begin
         unique case (act)
            ACT_WRITE: begin
               if (req_address[15]) begin
                  unique case (reg_code)
                     REG_BANK_SELECT: begin
                        chr_mode_in   = req_value[7];
                        prg_mode_in   = req_value[6];
                        reg_select_in = req_value[REG_SEL_WIDTH-1:0];
                     end
                     REG_BANK_DATA:   bank_regs_in[reg_select_ff] = req_value;
                     REG_MIRROR:      mirror_bit_in = req_value[0];
                     REG_WRAM:        wram_bit_in = (req_value[7:6] == 2'b10);
                     REG_IRQ_LATCH:   irq_latch_in = req_value;
                     REG_IRQ_RELOAD:  reload_flag_in = 1'b1;
                     REG_IRQ_DISABLE: begin
                        irq_on_in   = 1'b0;
                        irq_flag_in = 1'b0;
                     end
                     REG_IRQ_ENABLE:  irq_on_in = 1'b1;
                     default:         ;
                  endcase
               end
            end
            ACT_TICK: begin
               if (irq_count_ff == '0 || reload_flag_ff) begin
                  irq_count_in   = irq_latch_ff;
                  reload_flag_in = 1'b0;
               end else begin
                  irq_count_in = irq_count_ff - 8'd1;
               end
               if (irq_count_in == '0 && irq_on_ff) begin
                  irq_flag_in = 1'b1;
               end
            end
            ACT_PRG:   rsp_bank_in = prg_bank;
            ACT_CHR:   rsp_bank_in = chr_bank;
            default:   ;
         endcase
      end
   end

   assign rsp_valid_in = accept | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         prg_count_ff   <= PRG_COUNT_RESET;
         chr_count_ff   <= CHR_COUNT_RESET;
         for (int i = 0; i < NUM_BANK_REGS; i++) begin
            bank_regs_ff[i] <= '0;
         end
         prg_mode_ff    <= 1'b0;
         chr_mode_ff    <= 1'b0;
         reg_select_ff  <= '0;
         irq_count_ff   <= '0;
         irq_latch_ff   <= '0;
         reload_flag_ff <= 1'b0;
         irq_on_ff      <= 1'b0;
         irq_flag_ff    <= 1'b0;
         mirror_bit_ff  <= 1'b0;
         wram_bit_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         prg_count_ff   <= prg_count_in;
         chr_count_ff   <= chr_count_in;
         bank_regs_ff   <= bank_regs_in;
         prg_mode_ff    <= prg_mode_in;
         chr_mode_ff    <= chr_mode_in;
         reg_select_ff  <= reg_select_in;
         irq_count_ff   <= irq_count_in;
         irq_latch_ff   <= irq_latch_in;
         reload_flag_ff <= reload_flag_in;
         irq_on_ff      <= irq_on_in;
         irq_flag_ff    <= irq_flag_in;
         mirror_bit_ff  <= mirror_bit_in;
         wram_bit_ff    <= wram_bit_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // response payload, status bits taken after the request's update
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_bank_ff   <= rsp_bank_in;
         rsp_irq_ff    <= irq_flag_in;
         rsp_mirror_ff <= mirror_bit_in;
         rsp_wram_ff   <= wram_bit_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_bank              = rsp_bank_ff;
   assign rsp_irq_pending       = rsp_irq_ff;
   assign rsp_mirror_horizontal = rsp_mirror_ff;
   assign rsp_wram_writable     = rsp_wram_ff;

endmodule

// ===== sv/bsm_checker.sv =====
// Port-level checker for the mapper, bound to the top level.
`timescale 1ns / 1ps
`include "bank_switch_mapper_scanline_irq_macros.svh"

module bsm_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic [bsm_pkg::ACTION_WIDTH-1:0]    req_action,
   input logic [bsm_pkg::ADDRESS_WIDTH-1:0]   req_address,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [bsm_pkg::BANK_WIDTH-1:0]      rsp_bank,
   input logic                                rsp_irq_pending
);
   import bsm_pkg::*;

   logic req_fire;
   logic ack_write;

   assign req_fire  = req_valid & req_ready;
   // write to the IRQ disable/acknowledge register
   assign ack_write = req_fire && req_action == ACT_WRITE &&
                      req_address[15:13] == 3'b111 && !req_address[0];

   `BSM_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `BSM_ASSERT_NOW(a_ready_when_empty, clock, reset, !rsp_valid, req_ready)
   `BSM_ASSERT_NEXT(a_ack_clears_irq, clock, reset, ack_write, !rsp_irq_pending)
   `BSM_ASSERT_NEXT(a_write_bank_zero, clock, reset,
      req_fire && (req_action == ACT_WRITE || req_action == ACT_TICK), rsp_bank == '0)
   `BSM_ASSERT_NEXT(a_low_prg_zero, clock, reset,
      req_fire && req_action == ACT_PRG && !req_address[15], rsp_bank == '0)

endmodule

bind bank_switch_mapper_scanline_irq bsm_checker u_bsm_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_action      (req_action),
   .req_address     (req_address),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_bank        (rsp_bank),
   .rsp_irq_pending (rsp_irq_pending)
);

// ===== dv/bank_switch_mapper_scanline_irq_test.sv =====
// Self-checking testbench for the bank-switching mapper with scanline IRQ.
`timescale 1ns / 1ps

module bank_switch_mapper_scanline_irq_test;
   import bsm_pkg::*;

   localparam int STALL_LIMIT = 3000;
   localparam int HOLD_CYCLES = 80;
   localparam int DRAIN_CYCLES = 8;
   // index 2 and 3 have no register behind them
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SPARE = 2'd3;

   typedef struct {
      logic [BANK_WIDTH-1:0] bank;
      logic                  irq_pending;
      logic                  mirror_horizontal;
      logic                  wram_writable;
   } mapper_status_type;

   typedef struct {
      action_type               action;
      logic [ADDRESS_WIDTH-1:0] address;
      logic [VALUE_WIDTH-1:0]   value;
   } mapper_request_type;

   typedef enum {DRAIN_FULL, DRAIN_COIN, DRAIN_MOSTLY} drain_pattern_type;

   // Mapper state mirror; expected status queued per accepted request.
   class mapper_scoreboard;
      bit [COUNT_WIDTH-1:0] prg_count;
      bit [COUNT_WIDTH-1:0] chr_count;
      bit [7:0]             bank_reg[NUM_BANK_REGS];
      bit                   prg_mode;
      bit                   chr_mode;
      bit [2:0]             reg_sel;
      bit [7:0]             irq_count;
      bit [7:0]             irq_latch;
      bit                   reload_pending;
      bit                   irq_enabled;
      bit                   irq_flag;
      bit                   mirror_bit;
      bit                   wram_bit;
      mapper_status_type    status_q[$];
      int                   errors;

      function new();
         prg_count = PRG_COUNT_RESET;
         chr_count = CHR_COUNT_RESET;
         foreach (bank_reg[i]) bank_reg[i] = '0;
         prg_mode = 0;
         chr_mode = 0;
         reg_sel = '0;
         irq_count = '0;
         irq_latch = '0;
         reload_pending = 0;
         irq_enabled = 0;
         irq_flag = 0;
         mirror_bit = 0;
         wram_bit = 0;
         errors = 0;
      endfunction

      function void set_count(logic [CSR_IDX_WIDTH-1:0] idx, logic [COUNT_WIDTH-1:0] data);
         case (idx)
            CSR_PRG_COUNT: prg_count = data;
            CSR_CHR_COUNT: chr_count = data;
            default: ;
         endcase
      endfunction

      function void note_request(action_type act, logic [15:0] addr, logic [7:0] val);
         mapper_status_type    st;
         bit [COUNT_WIDTH-1:0] span;
         bit [7:0]             mask;
         bit [7:0]             b;
         bit [2:0]             slot;
         reg_code_type         code;
         st.bank = '0;
         case (act)
            ACT_WRITE: if (addr[15]) begin
               code = reg_code_type'({addr[14:13], addr[0]});
               case (code)
                  REG_BANK_SELECT: begin
                     chr_mode = val[7];
                     prg_mode = val[6];
                     reg_sel = val[2:0];
                  end
                  REG_BANK_DATA:   bank_reg[reg_sel] = val;
                  REG_MIRROR:      mirror_bit = val[0];
                  REG_WRAM:        wram_bit = (val[7:6] == 2'b10);
                  REG_IRQ_LATCH:   irq_latch = val;
                  REG_IRQ_RELOAD:  reload_pending = 1;
                  REG_IRQ_DISABLE: begin
                     irq_enabled = 0;
                     irq_flag = 0;
                  end
                  REG_IRQ_ENABLE:  irq_enabled = 1;
               endcase
            end
            ACT_TICK: begin
               if (irq_count == 0 || reload_pending) begin
                  irq_count = irq_latch;
                  reload_pending = 0;
               end else begin
                  irq_count = irq_count - 8'd1;
               end
               if (irq_count == 0 && irq_enabled) irq_flag = 1;
            end
            ACT_PRG: if (addr[15]) begin
               span = prg_count - 9'd1;
               mask = span[7:0];
               case (addr[14:13])
                  2'd3: b = span[7:0];
                  2'd1: b = bank_reg[7];
                  default: begin
                     // R6 moves between the first and third slot with the mode
                     if ((addr[14:13] == 2'd0) == (prg_mode == 0)) begin
                        b = bank_reg[6];
                     end else begin
                        span = prg_count - 9'd2;
                        b = span[7:0];
                     end
                  end
               endcase
               st.bank = b & mask;
            end
            ACT_CHR: if (addr[15:13] == 3'd0) begin
               span = chr_count - 9'd1;
               mask = span[7:0];
               slot = addr[12:10] ^ {chr_mode, 2'b00};
               if (!slot[2]) begin
                  // 2K pairs from R0 and R1
                  b = bank_reg[{2'b00, slot[1]}];
                  b = slot[0] ? (b | 8'h01) : (b & 8'hFE);
               end else begin
                  b = bank_reg[slot - 3'd2];
               end
               st.bank = b & mask;
            end
         endcase
         st.irq_pending = irq_flag;
         st.mirror_horizontal = mirror_bit;
         st.wram_writable = wram_bit;
         status_q.push_back(st);
      endfunction

      function void check_response(mapper_status_type got);
         mapper_status_type want;
         if (status_q.size() == 0) begin
            $display("%0t unexpected response: expected none, actual bank %0h", $time,
                     got.bank);
            errors++;
            return;
         end
         want = status_q.pop_front();
         if (got.bank !== want.bank) begin
            $display("%0t bank mismatch: expected %0h actual %0h", $time, want.bank,
                     got.bank);
            errors++;
         end
         if (got.irq_pending !== want.irq_pending) begin
            $display("%0t irq_pending mismatch: expected %0b actual %0b", $time,
                     want.irq_pending, got.irq_pending);
            errors++;
         end
         if (got.mirror_horizontal !== want.mirror_horizontal) begin
            $display("%0t mirror_horizontal mismatch: expected %0b actual %0b", $time,
                     want.mirror_horizontal, got.mirror_horizontal);
            errors++;
         end
         if (got.wram_writable !== want.wram_writable) begin
            $display("%0t wram_writable mismatch: expected %0b actual %0b", $time,
                     want.wram_writable, got.wram_writable);
            errors++;
         end
      endfunction

      function int pending();
         return status_q.size();
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [ACTION_WIDTH-1:0]  req_action;
   logic [ADDRESS_WIDTH-1:0] req_address;
   logic [VALUE_WIDTH-1:0]   req_value;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic [BANK_WIDTH-1:0]    rsp_bank;
   logic                     rsp_irq_pending;
   logic                     rsp_mirror_horizontal;
   logic                     rsp_wram_writable;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CSR_IDX_WIDTH-1:0] csr_index;
   logic [COUNT_WIDTH-1:0]   csr_data;

   mapper_scoreboard sb = new();

   bank_switch_mapper_scanline_irq u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_action            (req_action),
      .req_address           (req_address),
      .req_value             (req_value),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_bank              (rsp_bank),
      .rsp_irq_pending       (rsp_irq_pending),
      .rsp_mirror_horizontal (rsp_mirror_horizontal),
      .rsp_wram_writable     (rsp_wram_writable),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   function automatic logic [15:0] reg_address(reg_code_type code);
      return {1'b1, code[2:1], 12'h000, code[0]};
   endfunction

   function automatic mapper_request_type random_request();
      mapper_request_type item;
      reg_code_type       code;
      int                 pick;
      pick = $urandom_range(0, 99);
      item.value = 8'($urandom);
      if (pick < 45) begin
         item.action = ACT_WRITE;
         code = reg_code_type'($urandom_range(0, 7));
         // don't-care address bits are randomized; decode is on E001h
         item.address = reg_address(code) | (16'($urandom) & 16'h1FFE);
         if (code == REG_IRQ_LATCH && $urandom_range(0, 3) != 0)
            item.value = 8'($urandom_range(0, 4));
         if ($urandom_range(0, 11) == 0) item.address = 16'($urandom_range(0, 16'h7FFF));
      end else if (pick < 70) begin
         item.action = ACT_TICK;
         item.address = 16'($urandom);
      end else if (pick < 85) begin
         item.action = ACT_PRG;
         item.address = 16'($urandom);
         if ($urandom_range(0, 3) != 0) item.address[15] = 1'b1;
      end else begin
         item.action = ACT_CHR;
         item.address = 16'($urandom);
         if ($urandom_range(0, 7) != 0) item.address[15:13] = 3'd0;
      end
      return item;
   endfunction

   // keep_valid leaves valid high for a back-to-back request
   task automatic send_request(action_type act, logic [15:0] addr, logic [7:0] val,
                               bit keep_valid);
      req_valid <= 1'b1;
      req_action <= act;
      req_address <= addr;
      req_value <= val;
      do @(posedge clock); while (!req_ready);
      sb.note_request(act, addr, val);
      if (!keep_valid) req_valid <= 1'b0;
   endtask

   task automatic write_count(logic [CSR_IDX_WIDTH-1:0] idx, logic [COUNT_WIDTH-1:0] data,
                              bit keep_valid);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      sb.set_count(idx, data);
      if (!keep_valid) csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_phase(logic [COUNT_WIDTH-1:0] prg, logic [COUNT_WIDTH-1:0] chr,
                            int items, bit poke_spare);
      mapper_request_type item;
      int                 burst_left;
      bit                 keep;
      wait_drained();
      write_count(CSR_PRG_COUNT, prg, 1'b1);
      if (poke_spare) write_count(CSR_SPARE, 9'h1FF, 1'b1);
      write_count(CSR_CHR_COUNT, chr, 1'b0);
      burst_left = 0;
      for (int i = 0; i < items; i++) begin
         if (burst_left == 0)
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
         burst_left--;
         item = random_request();
         keep = (burst_left > 0) && (i < items - 1);
         send_request(item.action, item.address, item.value, keep);
         if (!keep && i < items - 1) repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   // response side: check, then pick next ready
   initial begin
      int                rsp_seen;
      int                hold_left;
      int                stretch_left;
      drain_pattern_type pattern;
      mapper_status_type got;
      rsp_seen = 0;
      hold_left = 0;
      stretch_left = 0;
      pattern = DRAIN_FULL;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got.bank = rsp_bank;
            got.irq_pending = rsp_irq_pending;
            got.mirror_horizontal = rsp_mirror_horizontal;
            got.wram_writable = rsp_wram_writable;
            sb.check_response(got);
            rsp_seen++;
            // long hold-off so the mapper backs up into the request side
            if (rsp_seen == 300 || rsp_seen == 750) hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (stretch_left == 0) begin
               pattern = drain_pattern_type'($urandom_range(0, 2));
               stretch_left = $urandom_range(10, 60);
            end
            stretch_left--;
            case (pattern)
               DRAIN_FULL: rsp_ready <= 1'b1;
               DRAIN_COIN: rsp_ready <= 1'($urandom_range(0, 1));
               default:    rsp_ready <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin : watchdog
      int quiet_cycles;
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_action <= ACT_WRITE;
      req_address <= '0;
      req_value <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_PRG_COUNT;
      csr_data <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed pass at reset counts
      send_request(ACT_PRG, 16'h8000, 8'h00, 1'b1);
      send_request(ACT_PRG, 16'hC000, 8'h00, 1'b1);
      send_request(ACT_PRG, 16'hFFFF, 8'h00, 1'b1);
      send_request(ACT_PRG, 16'h7FFF, 8'h00, 1'b1);
      send_request(ACT_CHR, 16'h2000, 8'h00, 1'b1);
      send_request(ACT_WRITE, 16'h7FFF, 8'hFF, 1'b1);
      send_request(ACT_WRITE, reg_address(REG_BANK_SELECT), 8'hC6, 1'b1);
      send_request(ACT_WRITE, reg_address(REG_BANK_DATA), 8'hFF, 1'b1);
      send_request(ACT_PRG, 16'h8000, 8'h00, 1'b1);
      send_request(ACT_PRG, 16'hC000, 8'h00, 1'b1);
      send_request(ACT_CHR, 16'h0000, 8'h00, 1'b1);
      send_request(ACT_WRITE, reg_address(REG_BANK_SELECT), 8'h00, 1'b1);
      send_request(ACT_WRITE, reg_address(REG_BANK_DATA), 8'hFF, 1'b1);
      send_request(ACT_CHR, 16'h0000, 8'h00, 1'b1);
      send_request(ACT_CHR, 16'h07FF, 8'h00, 1'b1);
      send_request(ACT_WRITE, reg_address(REG_MIRROR), 8'h01, 1'b1);
      send_request(ACT_WRITE, reg_address(REG_WRAM), 8'h80, 1'b1);
      send_request(ACT_WRITE, reg_address(REG_IRQ_LATCH), 8'h01, 1'b1);
      send_request(ACT_WRITE, reg_address(REG_IRQ_RELOAD), 8'h00, 1'b1);
      send_request(ACT_WRITE, reg_address(REG_IRQ_ENABLE), 8'h00, 1'b1);
      send_request(ACT_TICK, 16'h0000, 8'h00, 1'b1);
      send_request(ACT_TICK, 16'hFFFF, 8'h00, 1'b1);
      send_request(ACT_TICK, 16'h0000, 8'h00, 1'b1);
      send_request(ACT_WRITE, reg_address(REG_IRQ_DISABLE), 8'h00, 1'b1);
      send_request(ACT_CHR, 16'h1FFF, 8'h00, 1'b0);

      run_phase(9'd4, 9'd8, 160, 1'b0);
      run_phase(9'd256, 9'd256, 160, 1'b0);
      run_phase(9'd0, 9'd0, 160, 1'b1);
      run_phase(9'd6, 9'd100, 160, 1'b0);
      run_phase(9'd511, 9'd3, 160, 1'b0);
      run_phase(9'(1 << $urandom_range(2, 8)), 9'(1 << $urandom_range(3, 8)), 160, 1'b0);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
